FILE: design/temp_pressure_compensation_defines.svh
// Assertion macros shared by the checker of the compensation block.
// Holds macros only; no other dependencies.
`ifndef TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/tpc_pkg.sv
// Package for the compensation block: payload structs, opcodes and register indexes.
// No dependencies.
`default_nettype none
package tpc_pkg;
    typedef struct packed {
        logic        command;
        logic [19:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] temperature_centi;
        logic        [31:0] pressure_pascal;
        logic               divide_by_zero;
    } t_out_item;

    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [1:0] REG_PRESS_P9  = 2'd3;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

FILE: design/tpc_divider.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// Uses tpc_pkg for the request and response structs.
`default_nettype none
module tpc_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpc_pkg::t_div_req i_req,
    output tpc_pkg::t_div_rsp      o_rsp
);
    import tpc_pkg::*;

    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_count;
    logic        r_busy, r_done;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    // One shift and subtract per cycle.
    assign w_shift = {r_rem, r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_rem   <= '0;
                r_quo   <= i_req.dividend;
                r_den   <= i_req.divisor;
                r_count <= 6'd32;
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shift[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_count <= r_count - 6'd1;
                if (r_count == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

FILE: design/temp_pressure_compensation.sv
// Top level of the barometric compensation block: sequencer around one shared multiplier.
// Uses tpc_pkg and tpc_divider.
//
//  Channel | Direction | Handshake          | Payload
//  input   | in        | i_in_valid/o_in_ready   | t_in_item
//  output  | out       | o_out_valid/i_out_ready | t_out_item
//  config  | in        | i_cfg_valid/o_cfg_ready | index 2 bits, data 64 bits
//
// Result timing is set by one 32x32 multiplier used once per step and, for a pressure
// request, the 32-step bit-serial divider, which holds the sequencer while it runs;
// a zero divisor makes the pressure request skip the divider.
// Reset is synchronous, active low, and clears the sequencer, result valid, fine temperature and calibration registers.
// The result register holds until taken; a new request is accepted once it is empty.
`default_nettype none
module temp_pressure_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tpc_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tpc_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    import tpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
        S_P11, S_PDIV, S_PWAIT, S_P12, S_P13, S_P14, S_P15, S_OUT
    } t_state;

    t_state      r_state;
    logic [47:0] r_tcal;
    logic [63:0] r_plo, r_phi;
    logic [15:0] r_p9;
    logic [31:0] r_fine;
    logic [19:0] r_adc;
    logic [31:0] r_a, r_b, r_c, r_d, r_p;
    logic [31:0] r_prod;
    logic        r_big;
    logic        r_out_valid;
    t_out_item   r_out;
    t_div_req    r_div;
    t_div_rsp    w_div;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_full;

    logic [31:0] w_t1, w_t2, w_t3;
    logic [31:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = {16'd0, r_tcal[15:0]};
    assign w_t2 = sx16(r_tcal[31:16]);
    assign w_t3 = sx16(r_tcal[47:32]);
    assign w_p1 = {16'd0, r_plo[15:0]};
    assign w_p2 = sx16(r_plo[31:16]);
    assign w_p3 = sx16(r_plo[47:32]);
    assign w_p4 = sx16(r_plo[63:48]);
    assign w_p5 = sx16(r_phi[15:0]);
    assign w_p6 = sx16(r_phi[31:16]);
    assign w_p7 = sx16(r_phi[47:32]);
    assign w_p8 = sx16(r_phi[63:48]);
    assign w_p9 = sx16(r_p9);

    tpc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div),
        .o_rsp  (w_div)
    );

    // Operand select for the shared multiplier; the product is registered.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_T1:  begin w_ma = r_a; w_mb = w_t2; end
            S_T2:  begin w_ma = r_b; w_mb = r_b;  end
            S_T3:  begin w_ma = asr32(r_prod, 12); w_mb = w_t3; end
            S_T4:  begin w_ma = r_fine; w_mb = 32'd5; end
            S_P1:  begin w_ma = r_b; w_mb = r_b;  end
            S_P2:  begin w_ma = asr32(r_prod, 11); w_mb = w_p6; end
            S_P3:  begin w_ma = r_a; w_mb = w_p5; end
            S_P4:  begin w_ma = asr32(r_d, 13); w_mb = w_p3; end
            S_P5:  begin w_ma = w_p2; w_mb = r_a; end
            S_P6:  begin w_ma = r_c + asr32(r_prod, 1); w_mb = 32'd1; end
            S_P7:  begin w_ma = 32'd32768 + asr32(r_prod, 18);
                         w_mb = w_p1; end
            S_P10: begin w_ma = 32'd1048576 - {12'd0, r_adc} - asr32(r_b, 12);
                         w_mb = 32'd3125; end
            S_P12: begin w_ma = {3'd0, r_p[31:3]}; w_mb = {3'd0, r_p[31:3]}; end
            S_P13: begin w_ma = w_p9; w_mb = {13'd0, r_prod[31:13]}; end
            S_P14: begin w_ma = {2'd0, r_p[31:2]}; w_mb = w_p8; end
            default: ;
        endcase
    end
    assign w_full = w_ma * w_mb;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer, working registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fine      <= '0;
            r_tcal      <= '0;
            r_plo       <= '0;
            r_phi       <= '0;
            r_p9        <= '0;
            r_div       <= '0;
        end else begin
            r_div.start <= (r_state == S_P11);
            r_prod      <= w_full[31:0];
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TEMP_CAL: r_tcal <= i_cfg_data[47:0];
                    REG_PRESS_LO: r_plo  <= i_cfg_data;
                    REG_PRESS_HI: r_phi  <= i_cfg_data;
                    REG_PRESS_P9: r_p9   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_adc <= i_in_data.raw_sample;
                        if (i_in_data.command == CMD_TEMP) begin
                            r_a     <= {15'd0, i_in_data.raw_sample[19:3]} - (w_t1 << 1);
                            r_b     <= {16'd0, i_in_data.raw_sample[19:4]} - w_t1;
                            r_state <= S_T1;
                        end else begin
                            r_a     <= asr32(r_fine, 1) - 32'd64000;
                            r_b     <= asr32(asr32(r_fine, 1) - 32'd64000, 2);
                            r_state <= S_P1;
                        end
                    end
                end
                S_T1: begin r_state <= S_T2; end
                S_T2: begin r_a <= asr32(r_prod, 11); r_state <= S_T3; end
                S_T3: begin r_state <= S_T5; end
                S_T5: begin
                    r_fine  <= r_a + asr32(r_prod, 14);
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_out.result_kind       <= CMD_TEMP;
                    r_out.temperature_centi <= asr32(w_full[31:0] + 32'd128, 8);
                    r_out.pressure_pascal   <= '0;
                    r_out.divide_by_zero    <= 1'b0;
                    r_state                 <= S_OUT;
                end
                S_P1: begin r_state <= S_P2; end
                S_P2: begin r_d <= r_prod; r_state <= S_P3; end
                S_P3: begin r_c <= r_prod; r_state <= S_P4; end
                S_P4: begin r_b <= r_c + (r_prod << 1); r_state <= S_P5; end
                S_P5: begin
                    r_b     <= asr32(r_b, 2) + (w_p4 << 16);
                    r_c     <= asr32(r_prod, 3);
                    r_state <= S_P6;
                end
                S_P6: begin r_state <= S_P7; end
                S_P7: begin r_state <= S_P8; end
                S_P8: begin
                    r_a     <= asr32(r_prod, 15);
                    r_state <= S_P9;
                end
                S_P9: begin
                    if (r_a == 32'd0) begin
                        r_out.result_kind       <= CMD_PRESS;
                        r_out.temperature_centi <= '0;
                        r_out.pressure_pascal   <= '0;
                        r_out.divide_by_zero    <= 1'b1;
                        r_state                 <= S_OUT;
                    end else begin
                        r_state <= S_P10;
                    end
                end
                S_P10: begin r_state <= S_P11; end
                S_P11: begin
                    r_big       <= r_prod[31];
                    r_div.dividend <= r_prod[31] ? r_prod : (r_prod << 1);
                    r_div.divisor  <= r_a;
                    r_state     <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (w_div.done) begin
                        r_p     <= r_big ? (w_div.quotient << 1) : w_div.quotient;
                        r_state <= S_P12;
                    end
                end
                S_P12: begin r_state <= S_P13; end
                S_P13: begin r_state <= S_PDIV; end
                S_PDIV: begin
                    r_c     <= asr32(r_prod, 12);
                    r_state <= S_P14;
                end
                S_P14: begin r_state <= S_P15; end
                S_P15: begin
                    r_out.result_kind       <= CMD_PRESS;
                    r_out.temperature_centi <= '0;
                    r_out.pressure_pascal   <= r_p + asr32(r_c + asr32(r_prod, 13) + w_p7, 4);
                    r_out.divide_by_zero    <= 1'b0;
                    r_state                 <= S_OUT;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/tpc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
// Uses the assertion macros from temp_pressure_compensation_defines.svh.
`default_nettype none
`include "temp_pressure_compensation_defines.svh"
module tpc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tpc_pkg::t_out_item o_out_data
);
    // A request accepted on input makes the block busy in the next cycle.
    `TPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // No input is taken while a result is waiting.
    `TPC_ASSERT_IMPL(a_no_accept_with_result, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // A held result keeps its payload.
    `TPC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    // A temperature result carries no pressure flag.
    `TPC_ASSERT_IMPL(a_temp_no_flag, i_clk, i_rst_n, o_out_valid && !o_out_data.result_kind,
        !o_out_data.divide_by_zero)
endmodule

bind temp_pressure_compensation tpc_checker u_tpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
`default_nettype wire
